// ----- hw/rtl/debounced_edge_counter_defines.svh -----
// assertion macros shared by the edge counter rtl
`ifndef DEBOUNCED_EDGE_COUNTER_DEFINES_SVH
`define DEBOUNCED_EDGE_COUNTER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define DEC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define DEC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/dec_pkg.sv -----
// types, codes and helpers for the debounced edge counter
package dec_pkg;

  localparam int unsigned CountW = 64;
  localparam int unsigned StampW = 32;
  localparam int unsigned WinW   = 16;

  // item kinds
  localparam logic [2:0] KIND_POLL  = 3'd0;
  localparam logic [2:0] KIND_INIT  = 3'd1;
  localparam logic [2:0] KIND_RESET = 3'd2;
  localparam logic [2:0] KIND_LOAD  = 3'd3;
  localparam logic [2:0] KIND_CLEAR = 3'd4;

  // edge modes
  localparam logic [1:0] EDGE_RISE = 2'd0;
  localparam logic [1:0] EDGE_FALL = 2'd1;
  localparam logic [1:0] EDGE_BOTH = 2'd2;

  // counter widths
  localparam logic [1:0] WSEL_8  = 2'd0;
  localparam logic [1:0] WSEL_16 = 2'd1;
  localparam logic [1:0] WSEL_32 = 2'd2;
  localparam logic [1:0] WSEL_64 = 2'd3;

  // register indexes
  localparam logic [2:0] REG_ENABLED    = 3'd0;
  localparam logic [2:0] REG_RUNNING    = 3'd1;
  localparam logic [2:0] REG_EDGE_MODE  = 3'd2;
  localparam logic [2:0] REG_COUNT_DOWN = 3'd3;
  localparam logic [2:0] REG_WIDTH_SEL  = 3'd4;
  localparam logic [2:0] REG_START_VAL  = 3'd5;
  localparam logic [2:0] REG_DEB_ON     = 3'd6;
  localparam logic [2:0] REG_DEB_WINDOW = 3'd7;

  localparam logic [WinW-1:0] DEFAULT_WINDOW = 16'd10;

  typedef struct packed {
    logic              enabled;
    logic              running;
    logic [1:0]        edge_mode;
    logic              count_down;
    logic [1:0]        width_select;
    logic [CountW-1:0] base_value;
    logic              debounce_on;
    logic [WinW-1:0]   debounce_window;
  } cfg_t;

  typedef struct packed {
    logic [CountW-1:0] count;
    logic              level;
    logic [StampW-1:0] stamp;
    logic              overflow;
  } state_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic              level;
    logic [StampW-1:0] now_ms;
    logic [CountW-1:0] load_value;
  } item_t;

  function automatic logic [CountW-1:0] width_max(input logic [1:0] wsel);
    logic [CountW-1:0] lim;
    case (wsel)
      WSEL_8:  lim = 64'h0000_0000_0000_00FF;
      WSEL_16: lim = 64'h0000_0000_0000_FFFF;
      WSEL_32: lim = 64'h0000_0000_FFFF_FFFF;
      default: lim = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return lim;
  endfunction

endpackage

// ----- hw/rtl/debounced_edge_counter.sv -----
// top level of the debounced edge counter
// Counts edges of a polled input level, one item per clock cycle sustained
// while the consumer holds out_ready. An accepted item lands in an input
// register; the step logic (one 64-bit increment and limit compare, one 32-bit
// elapsed-time compare) then updates the counter state and loads the result
// register once the output side is free, which raises out_valid. The
// result register keeps taking items while the consumer is ready; when it stalls,
// the input register holds one more item before in_ready drops. Every item gives
// exactly one result. The user must write registers only while the block is idle;
// the block does not enforce this. An init item clears the running register.
`include "debounced_edge_counter_defines.svh"

module debounced_edge_counter (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [2:0]                 cfg_idx,
  input  logic [dec_pkg::CountW-1:0] cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [2:0]                 in_kind,
  input  logic                       in_level,
  input  logic [dec_pkg::StampW-1:0] in_now_ms,
  input  logic [dec_pkg::CountW-1:0] in_load_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [dec_pkg::CountW-1:0] out_count,
  output logic                       out_overflow,
  output logic                       out_edge_counted
);
  import dec_pkg::*;

  cfg_t              cfg_r;
  state_t            st_r;
  state_t            st_nxt;
  item_t             item_r;
  logic              in_vld_r;
  logic              out_vld_r;
  logic [CountW-1:0] out_count_r;
  logic              out_ovf_r;
  logic              out_edge_r;
  logic              stop_run;
  logic              edge_hit;
  logic              advance;

  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;

  dec_step u_step (
    .cfg          (cfg_r),
    .st           (st_r),
    .item         (item_r),
    .st_nxt       (st_nxt),
    .stop_run     (stop_run),
    .edge_counted (edge_hit)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enabled         <= 1'b0;
      cfg_r.running         <= 1'b0;
      cfg_r.edge_mode       <= EDGE_RISE;
      cfg_r.count_down      <= 1'b0;
      cfg_r.width_select    <= WSEL_64;
      cfg_r.base_value      <= '0;
      cfg_r.debounce_on     <= 1'b0;
      cfg_r.debounce_window <= DEFAULT_WINDOW;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_ENABLED:    cfg_r.enabled         <= cfg_wdata[0];
          REG_RUNNING:    cfg_r.running         <= cfg_wdata[0];
          REG_EDGE_MODE:  cfg_r.edge_mode       <= cfg_wdata[1:0];
          REG_COUNT_DOWN: cfg_r.count_down      <= cfg_wdata[0];
          REG_WIDTH_SEL:  cfg_r.width_select    <= cfg_wdata[1:0];
          REG_START_VAL:  cfg_r.base_value      <= cfg_wdata;
          REG_DEB_ON:     cfg_r.debounce_on     <= cfg_wdata[0];
          REG_DEB_WINDOW: cfg_r.debounce_window <= cfg_wdata[WinW-1:0];
          default:        cfg_r.enabled         <= cfg_r.enabled;
        endcase
      end
      // init item stops the counter
      if (advance && stop_run) begin
        cfg_r.running <= 1'b0;
      end
    end
  end

  // counter state moves only when an item leaves the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.kind       <= in_kind;
      item_r.level      <= in_level;
      item_r.now_ms     <= in_now_ms;
      item_r.load_value <= in_load_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_count_r <= st_nxt.count;
      out_ovf_r   <= st_nxt.overflow;
      out_edge_r  <= edge_hit;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_count        = out_count_r;
  assign out_overflow     = out_ovf_r;
  assign out_edge_counted = out_edge_r;

  // a pending result always mirrors the live counter state
  `DEC_ASSERT_NOW(a_result_tracks_state, clk, rst_n, out_vld_r,
    (out_count_r == st_r.count) && (out_ovf_r == st_r.overflow),
    "pending result differs from counter state")

  `DEC_ASSERT_NOW(a_edge_needs_enable, clk, rst_n, out_vld_r && out_edge_r,
    cfg_r.enabled, "edge counted while counter disabled")

  `DEC_ASSERT_NEXT(a_init_stops, clk, rst_n, advance && (item_r.kind == KIND_INIT),
    !cfg_r.running && !st_r.overflow, "init item left counter running or flagged")

endmodule

// ----- hw/rtl/dec_step.sv -----
// next-state and result logic for one counter item
module dec_step (
  input  dec_pkg::cfg_t   cfg,
  input  dec_pkg::state_t st,
  input  dec_pkg::item_t  item,
  output dec_pkg::state_t st_nxt,
  output logic            stop_run,
  output logic            edge_counted
);
  import dec_pkg::*;

  logic [WinW-1:0]   win;
  logic [StampW-1:0] elapsed;
  logic [CountW-1:0] lim;
  logic [CountW-1:0] inc;
  logic              in_window;
  logic              poll_ok;
  logic              hit;

  assign win       = (cfg.debounce_window == '0) ? DEFAULT_WINDOW : cfg.debounce_window;
  assign elapsed   = item.now_ms - st.stamp;
  assign in_window = cfg.debounce_on && (elapsed < {{(StampW-WinW){1'b0}}, win});
  assign poll_ok   = cfg.enabled && cfg.running && !in_window;
  assign lim       = width_max(cfg.width_select);
  assign inc       = st.count + 64'd1;

  always_comb begin
    case (cfg.edge_mode)
      EDGE_RISE: hit = !st.level && item.level;
      EDGE_FALL: hit = st.level && !item.level;
      EDGE_BOTH: hit = st.level != item.level;
      default:   hit = 1'b0;
    endcase
  end

  assign edge_counted = (item.kind == KIND_POLL) && poll_ok && hit;

  always_comb begin
    st_nxt   = st;
    stop_run = 1'b0;
    case (item.kind)
      KIND_POLL: begin
        if (poll_ok) begin
          st_nxt.level = item.level;
          if (hit) begin
            if (!cfg.count_down) begin
              // 64-bit mode wraps to zero through the adder itself
              if (inc > lim) begin
                st_nxt.count    = cfg.base_value;
                st_nxt.overflow = 1'b1;
              end else begin
                st_nxt.count = inc;
              end
            end else if (st.count != '0) begin
              st_nxt.count = st.count - 64'd1;
            end else begin
              st_nxt.count    = lim;
              st_nxt.overflow = 1'b1;
            end
            if (cfg.debounce_on) begin
              st_nxt.stamp = item.now_ms;
            end
          end
        end
      end
      KIND_INIT: begin
        st_nxt.count    = cfg.base_value;
        st_nxt.level    = item.level;
        st_nxt.stamp    = item.now_ms;
        st_nxt.overflow = 1'b0;
        stop_run        = 1'b1;
      end
      KIND_RESET: begin
        st_nxt.count = cfg.base_value;
        st_nxt.stamp = '0;
      end
      KIND_LOAD: begin
        st_nxt.count = item.load_value;
      end
      KIND_CLEAR: begin
        st_nxt.overflow = 1'b0;
      end
      default: begin
        st_nxt = st;
      end
    endcase
  end

endmodule
